// ----- hdl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion wrappers, compiled out in synthesis builds
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// property must hold at every clock edge outside reset
`define ASSERT_PROP(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error(msg);
// expression must never be true outside reset
`define ASSERT_NEVER(lbl, clk, rst, expr, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error(msg);
`else
`define ASSERT_PROP(lbl, clk, rst, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst, expr, msg)
`endif

`endif

// ----- hdl/kvt_pkg.sv -----
// ----------------------------------------------------------------------------
// kvt_pkg
// Shared types and constants of the keyed vector table
// ----------------------------------------------------------------------------
package kvt_pkg;

   localparam int KVT_MAX_ENTRIES = 64;
   localparam int KEY_W           = 32;
   localparam int COMP_W          = 64;

   localparam logic OP_UPSERT = 1'b0;
   localparam logic OP_LOOKUP = 1'b1;

   typedef struct packed {
      logic [COMP_W-1:0] z;
      logic [COMP_W-1:0] y;
      logic [COMP_W-1:0] x;
   } vec_type;

   // status of one key scan
   typedef struct packed {
      logic done;
      logic hit;
   } srch_stat_type;

   function automatic int kvt_idx_width(input int depth);
      int w;
      w = $clog2(depth);
      return (w < 1) ? 1 : w;
   endfunction

   function automatic int kvt_cnt_width(input int depth);
      return $clog2(depth + 1);
   endfunction

endpackage

// ----- hdl/keyed_vector_table_upsert_top.sv -----
// ----------------------------------------------------------------------------
// keyed_vector_table_upsert_top
// Key to vector table with insert-or-update and lookup
// ----------------------------------------------------------------------------
// Usage:
//   req channel: one word per operation. tuser carries the opcode (upsert or
//   lookup), tdata the key and the three vector components. rsp channel: one
//   word per request with the changed, found and full flags and the stored
//   vector on a lookup hit.
//   The used keys are compared one per cycle by a single comparator, in
//   entry order, through a registered key memory read. On a hit the stored
//   vector is then read through the registered vector memory port before
//   the response is formed. On a miss the response follows once every used
//   entry has been compared, with no key read at all on an empty table.
//   req_tready is high only while no item is in progress and rises together
//   with rsp_tvalid, so a new request is taken only once the last is done.
//   The response sits in an output register; if the receiver stalls, the
//   next finished item waits until that register is taken. Reset empties
//   the table at once (the entry count goes to zero); the memories
//   themselves are not cleared.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module keyed_vector_table_upsert_top
   import kvt_pkg::*;
#(
   parameter int MAX_ENTRIES = KVT_MAX_ENTRIES
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [223:0] req_tdata,   // cell_key, normal_x, normal_y, normal_z
   input  logic [0:0]   req_tuser,   // opcode
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [199:0] rsp_tdata    // changed, found, table_full, stored_x,
                                     // stored_y, stored_z, zero fill
);

   localparam int IDX_W = kvt_idx_width(MAX_ENTRIES);
   localparam int CNT_W = kvt_cnt_width(MAX_ENTRIES);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_SEARCH = 3'd1;
   localparam logic [2:0] ST_VREAD  = 3'd2;
   localparam logic [2:0] ST_FINISH = 3'd3;

   logic [2:0]       state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             rsp_valid_ff, rsp_valid_in;

   logic             op_ff;
   logic [KEY_W-1:0] key_ff;
   vec_type          vec_ff;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic             found_ff, found_in;
   logic             chg_ff, chg_in;
   logic             full_ff, full_in;
   vec_type          stored_ff, stored_in;
   logic [199:0]     rsp_data_ff;

   srch_stat_type    srch_stat;
   logic [IDX_W-1:0] srch_idx;
   vec_type          vec_q;

   logic             req_fire;
   logic             out_free;
   logic             key_wr_en;
   logic             vec_wr_en;
   logic [IDX_W-1:0] vec_wr_addr;
   logic             vec_rd_en;
   logic             table_has_room;

   assign req_tready     = (state_ff == ST_IDLE);
   assign req_fire       = req_tvalid && req_tready;
   assign out_free       = !rsp_valid_ff || rsp_tready;
   assign table_has_room = (count_ff < CNT_W'(MAX_ENTRIES));

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff;
      idx_in       = idx_ff;
      found_in     = found_ff;
      chg_in       = chg_ff;
      full_in      = full_ff;
      stored_in    = stored_ff;
      key_wr_en    = 1'b0;
      vec_wr_en    = 1'b0;
      vec_wr_addr  = idx_ff;
      vec_rd_en    = 1'b0;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               state_in = ST_SEARCH;
            end
         end
         ST_SEARCH: begin
            if (srch_stat.done) begin
               found_in  = srch_stat.hit;
               idx_in    = srch_idx;
               chg_in    = 1'b0;
               full_in   = 1'b0;
               stored_in = '0;
               if (srch_stat.hit) begin
                  vec_rd_en = 1'b1;
                  state_in  = ST_VREAD;
               end else begin
                  if (op_ff == OP_UPSERT) begin
                     if (table_has_room) begin
                        // append at the end of the used entries
                        key_wr_en   = 1'b1;
                        vec_wr_en   = 1'b1;
                        vec_wr_addr = count_ff[IDX_W-1:0];
                        count_in    = count_ff + CNT_W'(1);
                        chg_in      = 1'b1;
                     end else begin
                        full_in = 1'b1;
                     end
                  end
                  state_in = ST_FINISH;
               end
            end
         end
         ST_VREAD: begin
            if (op_ff == OP_UPSERT) begin
               chg_in    = (vec_q != vec_ff);
               vec_wr_en = 1'b1;
            end else begin
               stored_in = vec_q;
            end
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         op_ff    <= req_tuser[0];
         key_ff   <= req_tdata[31:0];
         vec_ff.x <= req_tdata[95:32];
         vec_ff.y <= req_tdata[159:96];
         vec_ff.z <= req_tdata[223:160];
      end
      idx_ff    <= idx_in;
      found_ff  <= found_in;
      chg_ff    <= chg_in;
      full_ff   <= full_in;
      stored_ff <= stored_in;
      if (state_ff == ST_FINISH && out_free) begin
         rsp_data_ff <= {5'b0, stored_ff.z, stored_ff.y, stored_ff.x,
                         full_ff, found_ff, chg_ff};
      end
   end

   kvt_search #(
      .MAX_ENTRIES (MAX_ENTRIES),
      .IDX_W       (IDX_W),
      .CNT_W       (CNT_W)
   ) u_search (
      .clock       (clock),
      .reset       (reset),
      .start       (req_fire),
      .key         (key_ff),
      .count       (count_ff),
      .key_wr_en   (key_wr_en),
      .key_wr_addr (count_ff[IDX_W-1:0]),
      .key_wr_data (key_ff),
      .stat        (srch_stat),
      .hit_idx     (srch_idx)
   );

   kvt_vec_mem #(
      .MAX_ENTRIES (MAX_ENTRIES),
      .IDX_W       (IDX_W)
   ) u_vec_mem (
      .clock   (clock),
      .wr_en   (vec_wr_en),
      .wr_addr (vec_wr_addr),
      .wr_data (vec_ff),
      .rd_en   (vec_rd_en),
      .rd_addr (srch_idx),
      .rd_data (vec_q)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   `ASSERT_NEVER(a_count_range, clock, reset, count_ff > CNT_W'(MAX_ENTRIES),
                 "entry count over capacity")
   `ASSERT_PROP(a_accept_search, clock, reset, req_fire |=> (state_ff == ST_SEARCH),
                "accepted word did not start a scan")
   `ASSERT_PROP(a_append_count, clock, reset,
                key_wr_en |=> (count_ff == $past(count_ff) + CNT_W'(1)),
                "append did not advance entry count")
   `ASSERT_NEVER(a_found_full, clock, reset, rsp_tvalid && rsp_tdata[1] && rsp_tdata[2],
                 "found and full together")
   `ASSERT_NEVER(a_wr_outside_item, clock, reset, vec_wr_en && (state_ff == ST_IDLE),
                 "vector write while idle")

endmodule

// ----- hdl/kvt_search.sv -----
// ----------------------------------------------------------------------------
// kvt_search
// Key memory with one shared comparator stepping over the used entries
// ----------------------------------------------------------------------------
module kvt_search
   import kvt_pkg::*;
#(
   parameter int MAX_ENTRIES = KVT_MAX_ENTRIES,
   parameter int IDX_W       = kvt_idx_width(MAX_ENTRIES),
   parameter int CNT_W       = kvt_cnt_width(MAX_ENTRIES)
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [KEY_W-1:0]    key,
   input  logic [CNT_W-1:0]    count,
   input  logic                key_wr_en,
   input  logic [IDX_W-1:0]    key_wr_addr,
   input  logic [KEY_W-1:0]    key_wr_data,
   output srch_stat_type       stat,
   output logic [IDX_W-1:0]    hit_idx
);

   logic [KEY_W-1:0] key_mem [MAX_ENTRIES];

   logic             scan_ff,   scan_in;
   logic [CNT_W-1:0] addr_ff,   addr_in;
   logic             rd_vld_ff, rd_vld_in;
   logic [IDX_W-1:0] rd_idx_ff;
   logic [KEY_W-1:0] rd_q_ff;

   logic issue;
   logic match;
   logic done;

   assign issue = scan_ff && (addr_ff < count);
   assign match = rd_vld_ff && (rd_q_ff == key);
   // done on a hit, or once every used entry has been read and compared
   assign done  = scan_ff && (match || (!issue && !rd_vld_ff));

   always_comb begin
      scan_in   = scan_ff;
      addr_in   = addr_ff;
      rd_vld_in = issue;
      if (start) begin
         scan_in   = 1'b1;
         addr_in   = '0;
         rd_vld_in = 1'b0;
      end else begin
         if (issue) begin
            addr_in = addr_ff + CNT_W'(1);
         end
         if (done) begin
            scan_in   = 1'b0;
            rd_vld_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_ff   <= 1'b0;
         addr_ff   <= '0;
         rd_vld_ff <= 1'b0;
      end else begin
         scan_ff   <= scan_in;
         addr_ff   <= addr_in;
         rd_vld_ff <= rd_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (key_wr_en) begin
         key_mem[key_wr_addr] <= key_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (issue) begin
         rd_q_ff   <= key_mem[addr_ff[IDX_W-1:0]];
         rd_idx_ff <= addr_ff[IDX_W-1:0];
      end
   end

   assign stat.done = done;
   assign stat.hit  = match;
   assign hit_idx   = rd_idx_ff;

endmodule

// ----- hdl/kvt_vec_mem.sv -----
// ----------------------------------------------------------------------------
// kvt_vec_mem
// Vector store, one write port and one registered read port
// ----------------------------------------------------------------------------
module kvt_vec_mem
   import kvt_pkg::*;
#(
   parameter int MAX_ENTRIES = KVT_MAX_ENTRIES,
   parameter int IDX_W       = kvt_idx_width(MAX_ENTRIES)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [IDX_W-1:0] wr_addr,
   input  vec_type          wr_data,
   input  logic             rd_en,
   input  logic [IDX_W-1:0] rd_addr,
   output vec_type          rd_data
);

   vec_type vec_mem [MAX_ENTRIES];
   vec_type rd_q_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         vec_mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_q_ff <= vec_mem[rd_addr];
      end
   end

   assign rd_data = rd_q_ff;

endmodule

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the keyed vector table upsert block
// ----------------------------------------------------------------------------
// Runs a directed set of upserts and lookups first, then random traffic that
// fills the table, drives it into the full condition and keeps updating and
// reading present keys. An in-bench table model predicts every response word,
// and a monitor compares each accepted word field by field against the oldest
// prediction. Sender and receiver stall at random, but for the last phase,
// which runs with no stalls, with a settle between phases.
// ----------------------------------------------------------------------------
module tb_top;
   import kvt_pkg::*;

   localparam int CLK_PERIOD   = 12;
   localparam int RESET_CYCLES = 12;
   localparam int DRAIN_CYCLES = 100;

   logic         clock      = 1'b0;
   logic         reset      = 1'b1;
   logic         req_tvalid = 1'b0;
   logic [223:0] req_tdata  = '0;   // cell_key, normal_x, normal_y, normal_z
   logic [0:0]   req_tuser  = '0;   // opcode
   logic         rsp_tready = 1'b0;
   logic         req_tready;
   logic         rsp_tvalid;
   logic [199:0] rsp_tdata;         // changed, found, table_full, stored_x,
                                    // stored_y, stored_z, zero fill

   typedef struct packed {
      logic    changed;
      logic    found;
      logic    full;
      vec_type stored;
   } rsp_word_type;

   // bench copy of the table
   logic [KEY_W-1:0] tbl_key [KVT_MAX_ENTRIES];
   vec_type          tbl_vec [KVT_MAX_ENTRIES];
   int               tbl_count = 0;

   rsp_word_type pending_rsp [$];
   int           error_count   = 0;
   int           send_idle_pct = 11;
   int           recv_idle_pct = 73;

   keyed_vector_table_upsert_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      forever #(CLK_PERIOD / 2) clock = ~clock;
   end

   initial begin
      #(25_000_000);
      $display("FAILED: results differ");
      $finish;
   end

   function automatic int find_slot(input logic [KEY_W-1:0] key);
      for (int i = 0; i < tbl_count; i++) begin
         if (tbl_key[i] == key) return i;
      end
      return -1;
   endfunction

   // applies one operation to the bench table and returns the response word
   function automatic rsp_word_type table_upsert_predict(input logic op,
                                                         input logic [KEY_W-1:0] key,
                                                         input vec_type v);
      rsp_word_type r;
      int slot;
      r = '0;
      slot = find_slot(key);
      r.found = (slot >= 0);
      if (op == OP_UPSERT) begin
         if (slot >= 0) begin
            r.changed = (tbl_vec[slot] != v);
            tbl_vec[slot] = v;
         end else if (tbl_count < KVT_MAX_ENTRIES) begin
            tbl_key[tbl_count] = key;
            tbl_vec[tbl_count] = v;
            tbl_count++;
            r.changed = 1'b1;
         end else begin
            r.full = 1'b1;
         end
      end else if (slot >= 0) begin
         r.stored = tbl_vec[slot];
      end
      return r;
   endfunction

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   function automatic vec_type rand_vec();
      vec_type v;
      v.x = rand64();
      v.y = rand64();
      v.z = rand64();
      return v;
   endfunction

   function automatic logic [KEY_W-1:0] fresh_key();
      logic [KEY_W-1:0] k;
      k = $urandom;
      while (find_slot(k) >= 0) k = $urandom;
      return k;
   endfunction

   // leaves req_tvalid high so a following word can go out back to back
   task automatic send_word(input logic op, input logic [KEY_W-1:0] key,
                            input vec_type v);
      rsp_word_type pred;
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {v, key};
      do @(posedge clock); while (req_tready !== 1'b1);
      pred = table_upsert_predict(op, key, v);
      pending_rsp = {pending_rsp, pred};
   endtask

   // sender holds off until every predicted word has come back
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic check_field(input string name, input logic [63:0] want,
                              input logic [63:0] got);
      if (got !== want) begin
         $error("%s: expected %0h, actual %0h", name, want, got);
         error_count++;
      end
   endtask

   always @(posedge clock) begin
      rsp_word_type want;
      rsp_word_type got;
      if (rsp_tvalid === 1'b1 && rsp_tready === 1'b1) begin
         got.changed = rsp_tdata[0];
         got.found   = rsp_tdata[1];
         got.full    = rsp_tdata[2];
         got.stored  = rsp_tdata[194:3];
         if (pending_rsp.size() == 0) begin
            $error("response word with no prediction waiting");
            error_count++;
         end else begin
            want = pending_rsp.pop_front();
            check_field("changed", 64'(want.changed), 64'(got.changed));
            check_field("found", 64'(want.found), 64'(got.found));
            check_field("table_full", 64'(want.full), 64'(got.full));
            check_field("stored_x", want.stored.x, got.stored.x);
            check_field("stored_y", want.stored.y, got.stored.y);
            check_field("stored_z", want.stored.z, got.stored.z);
         end
      end
      rsp_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
   end

   task automatic test_directed();
      vec_type zeros;
      vec_type ones;
      vec_type v;
      zeros = '0;
      ones  = '1;
      // lookups on an empty table miss
      send_word(OP_LOOKUP, 32'h0000_0000, ones);
      send_word(OP_LOOKUP, 32'hFFFF_FFFF, ones);
      send_word(OP_UPSERT, 32'h0000_0000, zeros);
      send_word(OP_UPSERT, 32'hFFFF_FFFF, ones);
      // same vector again, no change
      send_word(OP_UPSERT, 32'h0000_0000, zeros);
      // one component at a time differs
      v = zeros;
      v.x = '1;
      send_word(OP_UPSERT, 32'h0000_0000, v);
      v.y = '1;
      send_word(OP_UPSERT, 32'h0000_0000, v);
      v.z = '1;
      send_word(OP_UPSERT, 32'h0000_0000, v);
      send_word(OP_UPSERT, 32'hFFFF_FFFF, ones);
      send_word(OP_LOOKUP, 32'h0000_0000, zeros);
      send_word(OP_LOOKUP, 32'hFFFF_FFFF, zeros);
      send_word(OP_LOOKUP, 32'h0000_0001, ones);
      v.x = 64'h8000_0000_0000_0000;
      v.y = 64'h0000_0000_0000_0001;
      v.z = 64'h5555_AAAA_5555_AAAA;
      send_word(OP_UPSERT, 32'h8000_0000, v);
      send_word(OP_LOOKUP, 32'h8000_0000, ones);
      send_word(OP_UPSERT, 32'h0000_0000, zeros);
      send_word(OP_LOOKUP, 32'h0000_0000, ones);
   endtask

   task automatic test_random(input int n);
      int               kind;
      int               idx;
      logic [KEY_W-1:0] key;
      vec_type          v;
      for (int i = 0; i < n; i++) begin
         kind = $urandom_range(0, 99);
         idx  = (tbl_count > 0) ? $urandom_range(0, tbl_count - 1) : 0;
         v    = rand_vec();
         if (kind < 40 && tbl_count > 0) begin
            // update of a present key: same vector, one component, or all new
            key = tbl_key[idx];
            case ($urandom_range(0, 3))
               0: v = tbl_vec[idx];
               1: begin
                  v = tbl_vec[idx];
                  case ($urandom_range(0, 2))
                     0: v.x = rand64();
                     1: v.y = rand64();
                     default: v.z = rand64();
                  endcase
               end
               default: ;
            endcase
            send_word(OP_UPSERT, key, v);
         end else if (kind < 65 && tbl_count > 0) begin
            send_word(OP_LOOKUP, tbl_key[idx], v);
         end else if (kind < 82) begin
            send_word(OP_UPSERT, fresh_key(), v);
         end else begin
            send_word(OP_LOOKUP, $urandom, v);
         end
      end
   endtask

   task automatic test_table_full();
      logic [KEY_W-1:0] dropped;
      int               idx;
      while (tbl_count < KVT_MAX_ENTRIES) send_word(OP_UPSERT, fresh_key(), rand_vec());
      // new keys are dropped once every entry is used
      repeat (3) begin
         dropped = fresh_key();
         send_word(OP_UPSERT, dropped, rand_vec());
      end
      send_word(OP_LOOKUP, dropped, rand_vec());
      // present keys still update on a full table
      idx = KVT_MAX_ENTRIES - 1;
      send_word(OP_UPSERT, tbl_key[idx], rand_vec());
      send_word(OP_LOOKUP, tbl_key[idx], rand_vec());
      send_word(OP_UPSERT, tbl_key[0], tbl_vec[0]);
      send_word(OP_LOOKUP, tbl_key[0], rand_vec());
   endtask

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_idle_pct = 11;
      recv_idle_pct = 73;
      test_directed();
      test_random(500);
      wait_drained();
      test_table_full();
      wait_drained();

      send_idle_pct = 73;
      recv_idle_pct = 11;
      test_random(600);
      wait_drained();

      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_random(600);
      wait_drained();

      if (error_count == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule
